[sv/rfps_pkg.sv]
// ----------------------------------------------------------------------------
// rfps_pkg
// Shared types and constants for the ring FIFO with peek and skip.
// ----------------------------------------------------------------------------
`default_nettype none

package rfps_pkg;

   localparam int DEPTH      = 256;
   localparam int ELEM_BITS  = 8;
   localparam int MAX_BURST  = 64;
   localparam int SLOT_BITS  = $clog2(DEPTH);
   localparam int IDX_BITS   = SLOT_BITS + 1;
   localparam int CNT_BITS   = 9;
   localparam int CAPL_BITS  = 4;
   localparam int BURST_BITS = $clog2(MAX_BURST + 1);

   localparam logic [CAPL_BITS-1:0] CAPL_MIN   = CAPL_BITS'(1);
   localparam logic [CAPL_BITS-1:0] CAPL_MAX   = CAPL_BITS'(SLOT_BITS);
   localparam logic [CAPL_BITS-1:0] CAPL_RESET = CAPL_BITS'(SLOT_BITS);

   localparam logic [2:0] REQ_PUSH   = 3'd0;
   localparam logic [2:0] REQ_POP    = 3'd1;
   localparam logic [2:0] REQ_PEEK   = 3'd2;
   localparam logic [2:0] REQ_SKIP   = 3'd3;
   localparam logic [2:0] REQ_LINEAR = 3'd4;

   typedef struct packed {
      logic [2:0]           req_type;
      logic [ELEM_BITS-1:0] push_data;
      logic [CNT_BITS-1:0]  count;
   } rfps_req_item_type;

   typedef struct packed {
      logic [ELEM_BITS-1:0] read_data;
      logic                 data_valid;
      logic                 last;
      logic [CNT_BITS-1:0]  done_count;
      logic [SLOT_BITS-1:0] read_offset;
   } rfps_rsp_item_type;

   typedef struct packed {
      logic                 wr_en;
      logic [SLOT_BITS-1:0] wr_addr;
      logic [ELEM_BITS-1:0] wr_data;
      logic                 rd_en;
      logic [SLOT_BITS-1:0] rd_addr;
   } rfps_ram_cmd_type;

endpackage

`default_nettype wire

[sv/rfps_slot_ram.sv]
// ----------------------------------------------------------------------------
// rfps_slot_ram
// Slot store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module rfps_slot_ram
   import rfps_pkg::*;
(
   input  wire logic                 clock,
   input  wire rfps_ram_cmd_type     cmd,
   output logic      [ELEM_BITS-1:0] rd_data
);

   logic [ELEM_BITS-1:0] mem [DEPTH];
   logic [ELEM_BITS-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         mem[cmd.wr_addr] <= cmd.wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rd_en) begin
         rd_data_ff <= mem[cmd.rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

[sv/rfps_ctrl.sv]
// ----------------------------------------------------------------------------
// rfps_ctrl
// Index registers, request decode and burst sequencer around the slot store.
// ----------------------------------------------------------------------------
`default_nettype none

module rfps_ctrl
   import rfps_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic [CAPL_BITS-1:0]   cap_log2,
   input  wire logic                   start,
   input  wire rfps_req_item_type      req_item,
   output logic                        busy,
   output rfps_ram_cmd_type            ram_cmd,
   input  wire logic [ELEM_BITS-1:0]   ram_rd_data,
   output logic                        rsp_strobe,
   output rfps_rsp_item_type           rsp_item
);

   typedef enum logic [1:0] {
      ST_IDLE  = 2'b01,
      ST_BURST = 2'b10
   } state_type;

   state_type               state_ff, state_in;
   logic [IDX_BITS-1:0]     wr_idx_ff, wr_idx_in;
   logic [IDX_BITS-1:0]     rd_idx_ff, rd_idx_in;
   logic [BURST_BITS-1:0]   n_ff, n_in;
   logic [BURST_BITS-1:0]   i_ff, i_in;
   logic                    pop_ff, pop_in;
   logic                    single_strobe_ff, single_strobe_in;
   rfps_rsp_item_type       single_ff, single_in;

   logic [IDX_BITS-1:0]     cap;
   logic [SLOT_BITS-1:0]    mask;
   logic [IDX_BITS-1:0]     used;
   logic [CNT_BITS-1:0]     cnt_cap;
   logic [BURST_BITS-1:0]   n_rd;
   logic [SLOT_BITS-1:0]    off;
   logic [IDX_BITS-1:0]     span;
   logic [IDX_BITS-1:0]     next_rd;
   logic                    accept;
   logic                    burst_last;

   always_comb begin
      cap        = IDX_BITS'(1) << cap_log2;
      mask       = SLOT_BITS'(cap - IDX_BITS'(1));
      used       = wr_idx_ff - rd_idx_ff;
      cnt_cap    = (req_item.count < CNT_BITS'(used)) ? req_item.count : CNT_BITS'(used);
      n_rd       = (cnt_cap > CNT_BITS'(MAX_BURST)) ? BURST_BITS'(MAX_BURST)
                                                   : BURST_BITS'(cnt_cap);
      off        = SLOT_BITS'(rd_idx_ff) & mask;
      span       = cap - {1'b0, off};
      accept     = start && (state_ff == ST_IDLE);
      burst_last = ((i_ff + BURST_BITS'(1)) == n_ff);
      next_rd    = rd_idx_ff + IDX_BITS'(i_ff) + IDX_BITS'(1);

      state_in         = state_ff;
      wr_idx_in        = wr_idx_ff;
      rd_idx_in        = rd_idx_ff;
      n_in             = n_ff;
      i_in             = i_ff;
      pop_in           = pop_ff;
      single_strobe_in = 1'b0;
      single_in        = '0;
      single_in.last   = 1'b1;
      ram_cmd          = '0;
      ram_cmd.wr_addr  = SLOT_BITS'(wr_idx_ff) & mask;
      ram_cmd.wr_data  = req_item.push_data;
      ram_cmd.rd_addr  = off;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               single_strobe_in = 1'b1;
               case (req_item.req_type)
                  REQ_PUSH: begin
                     if (used < cap) begin
                        ram_cmd.wr_en        = 1'b1;
                        wr_idx_in            = wr_idx_ff + IDX_BITS'(1);
                        single_in.done_count = CNT_BITS'(1);
                     end
                  end
                  REQ_POP, REQ_PEEK: begin
                     if (n_rd != '0) begin
                        // elements come out of the burst path instead
                        single_strobe_in = 1'b0;
                        ram_cmd.rd_en    = 1'b1;
                        state_in         = ST_BURST;
                        n_in             = n_rd;
                        i_in             = '0;
                        pop_in           = (req_item.req_type == REQ_POP);
                     end
                  end
                  REQ_SKIP: begin
                     rd_idx_in            = rd_idx_ff + IDX_BITS'(cnt_cap);
                     single_in.done_count = cnt_cap;
                  end
                  REQ_LINEAR: begin
                     single_in.done_count  = (cnt_cap < CNT_BITS'(span)) ? cnt_cap
                                                                        : CNT_BITS'(span);
                     single_in.read_offset = off;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_BURST: begin
            i_in            = i_ff + BURST_BITS'(1);
            ram_cmd.rd_addr = SLOT_BITS'(next_rd) & mask;
            ram_cmd.rd_en   = !burst_last;
            if (burst_last) begin
               state_in = ST_IDLE;
               if (pop_ff) begin
                  rd_idx_in = rd_idx_ff + IDX_BITS'(n_ff);
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= ST_IDLE;
         wr_idx_ff        <= '0;
         rd_idx_ff        <= '0;
         n_ff             <= '0;
         i_ff             <= '0;
         pop_ff           <= 1'b0;
         single_strobe_ff <= 1'b0;
      end else begin
         state_ff         <= state_in;
         wr_idx_ff        <= wr_idx_in;
         rd_idx_ff        <= rd_idx_in;
         n_ff             <= n_in;
         i_ff             <= i_in;
         pop_ff           <= pop_in;
         single_strobe_ff <= single_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      single_ff <= single_in;
   end

   assign busy = (state_ff == ST_BURST);

   always_comb begin
      if (state_ff == ST_BURST) begin
         rsp_item.read_data   = ram_rd_data;
         rsp_item.data_valid  = 1'b1;
         rsp_item.last        = burst_last;
         rsp_item.done_count  = burst_last ? CNT_BITS'(n_ff) : '0;
         rsp_item.read_offset = '0;
      end else begin
         rsp_item = single_ff;
      end
   end

   assign rsp_strobe = (state_ff == ST_BURST) || single_strobe_ff;

   // burst and single-result paths never drive the output together
   assert property (@(posedge clock) disable iff (reset)
      !((state_ff == ST_BURST) && single_strobe_ff))
      else $error("burst and single result overlap");

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_BURST) |-> (i_ff < n_ff))
      else $error("burst counter past burst length");

   assert property (@(posedge clock) disable iff (reset)
      (wr_idx_ff - rd_idx_ff) <= IDX_BITS'(DEPTH))
      else $error("fill level beyond slot count");

   assert property (@(posedge clock) disable iff (reset)
      (accept && ram_cmd.rd_en) |=> (state_ff == ST_BURST) && (i_ff == '0))
      else $error("burst not started after read issue");

   assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_BURST) && burst_last) |=> (state_ff == ST_IDLE))
      else $error("burst did not end on last element");

endmodule

`default_nettype wire

[sv/ring_fifo_with_peek_skip_core.sv]
// ----------------------------------------------------------------------------
// ring_fifo_with_peek_skip_core
// Power-of-two ring FIFO with push, pop, peek, skip and linear span query.
//
//   channel  ports                          handshake
//   request  start, busy, req_item          taken when start && !busy
//   result   rsp_strobe, rsp_item           strobed with each item, no backpressure
//   config   csr_valid, csr_ready, csr_wdata written when valid && ready
//
// Push, skip, linear query, unused codes and empty pop/peek: result in the
// cycle after the request; the next request may follow immediately.
// Pop/peek of n elements (n capped at fill level and 64): n results from the
// slot store, one element a cycle, set by the single read port; busy holds to the last.
// Synchronous active-high reset clears both indices; capacity_log2 resets to 8.
// Slot contents are not cleared; no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module ring_fifo_with_peek_skip_core
   import rfps_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   output logic                       busy,
   input  wire rfps_req_item_type     req_item,
   output logic                       rsp_strobe,
   output rfps_rsp_item_type          rsp_item,
   input  wire logic                  csr_valid,
   output logic                       csr_ready,
   input  wire logic [CAPL_BITS-1:0]  csr_wdata
);

   logic [CAPL_BITS-1:0] cap_log2_ff, cap_log2_in;
   logic [CAPL_BITS-1:0] cap_log2_eff;
   rfps_ram_cmd_type     ram_cmd;
   logic [ELEM_BITS-1:0] ram_rd_data;

   assign csr_ready = 1'b1;

   always_comb begin
      cap_log2_in = (csr_valid && csr_ready) ? csr_wdata : cap_log2_ff;
      // out-of-range settings saturate
      if (cap_log2_ff < CAPL_MIN) begin
         cap_log2_eff = CAPL_MIN;
      end else if (cap_log2_ff > CAPL_MAX) begin
         cap_log2_eff = CAPL_MAX;
      end else begin
         cap_log2_eff = cap_log2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_log2_ff <= CAPL_RESET;
      end else begin
         cap_log2_ff <= cap_log2_in;
      end
   end

   rfps_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .cap_log2    (cap_log2_eff),
      .start       (start),
      .req_item    (req_item),
      .busy        (busy),
      .ram_cmd     (ram_cmd),
      .ram_rd_data (ram_rd_data),
      .rsp_strobe  (rsp_strobe),
      .rsp_item    (rsp_item)
   );

   rfps_slot_ram u_slot_ram (
      .clock   (clock),
      .cmd     (ram_cmd),
      .rd_data (ram_rd_data)
   );

endmodule

`default_nettype wire

[tb/sv/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for ring_fifo_with_peek_skip_core. A scoreboard class
// tracks indices, slot contents and capacity. It predicts the results of
// every accepted request and checks each strobed result in order. Stimulus is
// a directed opener, then random phases at several capacity settings, with
// fill-then-burst sequences mixed into single random requests.
// ----------------------------------------------------------------------------
module testbench;
   import rfps_pkg::*;

   localparam logic [2:0] REQ_UNUSED_FIRST = REQ_LINEAR + 3'd1;
   localparam logic [2:0] REQ_UNUSED_LAST  = 3'd7;

   // tracks FIFO state and holds results still owed by the block
   class ring_fifo_tracker;
      logic [ELEM_BITS-1:0] slot_mem [DEPTH];
      bit                   slot_written [DEPTH];
      logic [IDX_BITS-1:0]  wr_idx;
      logic [IDX_BITS-1:0]  rd_idx;
      logic [CAPL_BITS-1:0] cap_reg;
      rfps_rsp_item_type    owed_results [$];
      int                   errors;

      function new();
         wr_idx  = '0;
         rd_idx  = '0;
         cap_reg = CAPL_RESET;
         errors  = 0;
         foreach (slot_mem[i]) begin
            slot_mem[i]     = '0;
            slot_written[i] = 1'b0;
         end
      endfunction

      function int min_of(int a, int b);
         return (a < b) ? a : b;
      endfunction

      function int cap_slots();
         logic [CAPL_BITS-1:0] l;
         l = cap_reg;
         if (l < CAPL_MIN) l = CAPL_MIN;
         if (l > CAPL_MAX) l = CAPL_MAX;
         return 1 << l;
      endfunction

      function int fill_level();
         return int'(IDX_BITS'(wr_idx - rd_idx));
      endfunction

      function int pending();
         return owed_results.size();
      endfunction

      // number of consecutive written slots from the read position
      function int written_run(int limit);
         int cap;
         int k;
         cap = cap_slots();
         for (k = 0; k < limit; k++)
            if (!slot_written[(int'(rd_idx) + k) & (cap - 1)]) break;
         return k;
      endfunction

      function void set_capacity(logic [CAPL_BITS-1:0] value);
         cap_reg = value;
      endfunction

      function void predict_request(rfps_req_item_type it);
         rfps_rsp_item_type r;
         int cap;
         int used;
         int n;
         int off;
         int slot;
         cap  = cap_slots();
         used = fill_level();
         r    = '0;
         r.last = 1'b1;
         case (it.req_type)
            REQ_PUSH: begin
               if (used < cap) begin
                  slot               = int'(wr_idx) & (cap - 1);
                  slot_mem[slot]     = it.push_data;
                  slot_written[slot] = 1'b1;
                  wr_idx             = wr_idx + 1'b1;
                  r.done_count       = 1;
               end
               owed_results.push_back(r);
            end
            REQ_POP, REQ_PEEK: begin
               n = min_of(min_of(int'(it.count), used), MAX_BURST);
               if (n == 0) owed_results.push_back(r);
               for (int i = 0; i < n; i++) begin
                  r.read_data  = slot_mem[(int'(rd_idx) + i) & (cap - 1)];
                  r.data_valid = 1'b1;
                  r.last       = (i == n - 1);
                  r.done_count = (i == n - 1) ? CNT_BITS'(n) : '0;
                  owed_results.push_back(r);
               end
               if (it.req_type == REQ_POP) rd_idx = rd_idx + IDX_BITS'(n);
            end
            REQ_SKIP: begin
               n            = min_of(int'(it.count), used);
               rd_idx       = rd_idx + IDX_BITS'(n);
               r.done_count = CNT_BITS'(n);
               owed_results.push_back(r);
            end
            REQ_LINEAR: begin
               off           = int'(rd_idx) & (cap - 1);
               n             = min_of(min_of(int'(it.count), used), cap - off);
               r.done_count  = CNT_BITS'(n);
               r.read_offset = SLOT_BITS'(off);
               owed_results.push_back(r);
            end
            default: owed_results.push_back(r);
         endcase
      endfunction

      function void report(string field, int exp_v, int got_v);
         errors++;
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, exp_v, got_v);
      endfunction

      function void compare_result(rfps_rsp_item_type got);
         rfps_rsp_item_type exp_r;
         if (owed_results.size() == 0) begin
            errors++;
            $display("%0t: result with none expected, expected nothing, actual %h",
                     $time, got);
            return;
         end
         exp_r = owed_results.pop_front();
         if (got.read_data !== exp_r.read_data)
            report("read_data", exp_r.read_data, got.read_data);
         if (got.data_valid !== exp_r.data_valid)
            report("data_valid", exp_r.data_valid, got.data_valid);
         if (got.last !== exp_r.last)
            report("last", exp_r.last, got.last);
         if (got.done_count !== exp_r.done_count)
            report("done_count", exp_r.done_count, got.done_count);
         if (got.read_offset !== exp_r.read_offset)
            report("read_offset", exp_r.read_offset, got.read_offset);
      endfunction
   endclass

   logic                 clock     = 1'b0;
   logic                 reset     = 1'b1;
   logic                 start     = 1'b0;
   logic                 busy;
   rfps_req_item_type    req_item  = '0;
   logic                 rsp_strobe;
   rfps_rsp_item_type    rsp_item;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CAPL_BITS-1:0] csr_wdata = '0;

   ring_fifo_tracker     fifo_state = new();
   logic [CAPL_BITS-1:0] cap_plan [8] = '{4'd7, 4'd1, 4'd0, 4'd15, 4'd3, 4'd2, 4'd9, 4'd8};

   ring_fifo_with_peek_skip_core u_top (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_item   (req_item),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_wdata  (csr_wdata)
   );

   always #6 clock = ~clock;

   always @(posedge clock) begin
      if (!reset && rsp_strobe === 1'b1) fifo_state.compare_result(rsp_item);
   end

   function automatic rfps_req_item_type make_item(logic [2:0] op,
                                                   logic [ELEM_BITS-1:0] data,
                                                   logic [CNT_BITS-1:0] cnt);
      rfps_req_item_type it;
      it.req_type  = op;
      it.push_data = data;
      it.count     = cnt;
      return it;
   endfunction

   function automatic logic [CNT_BITS-1:0] rand_count();
      int pick;
      pick = $urandom_range(99);
      if (pick < 55) return CNT_BITS'($urandom_range(8));
      if (pick < 80) return CNT_BITS'($urandom_range(DEPTH));
      case ($urandom_range(3))
         0:       return '0;
         1:       return CNT_BITS'(MAX_BURST);
         2:       return CNT_BITS'(MAX_BURST + 1);
         default: return CNT_BITS'(DEPTH);
      endcase
   endfunction

   function automatic logic [2:0] rand_op();
      int pick;
      pick = $urandom_range(99);
      if (pick < 35) return REQ_PUSH;
      if (pick < 55) return REQ_POP;
      if (pick < 70) return REQ_PEEK;
      if (pick < 80) return REQ_SKIP;
      if (pick < 92) return REQ_LINEAR;
      return 3'(REQ_UNUSED_FIRST + $urandom_range(REQ_UNUSED_LAST - REQ_UNUSED_FIRST));
   endfunction

   task automatic send_item(rfps_req_item_type it, int idle_pct);
      int lim;
      int run;
      while ($urandom_range(99) < idle_pct) begin
         @(negedge clock);
         start <= 1'b0;
      end
      // never let a burst read reach a slot that was never written
      if (it.req_type == REQ_POP || it.req_type == REQ_PEEK) begin
         lim = fifo_state.min_of(fifo_state.fill_level(), MAX_BURST);
         run = fifo_state.written_run(lim);
         if (run < lim && int'(it.count) > run) it.count = CNT_BITS'(run);
      end
      @(negedge clock);
      start    <= 1'b1;
      req_item <= it;
      do @(posedge clock); while (busy);
      fifo_state.predict_request(it);
   endtask

   task automatic settle();
      @(negedge clock);
      start <= 1'b0;
      while (fifo_state.pending() != 0) @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   task automatic write_capacity(logic [CAPL_BITS-1:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      fifo_state.set_capacity(value);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic run_directed(int idle_pct);
      // empty FIFO: reads give the lone empty result, skip and span give zero
      send_item(make_item(REQ_POP,    8'h00, 9'd5),   idle_pct);
      send_item(make_item(REQ_PEEK,   8'hFF, 9'd0),   idle_pct);
      send_item(make_item(REQ_SKIP,   8'h00, 9'd3),   idle_pct);
      send_item(make_item(REQ_LINEAR, 8'h00, 9'd256), idle_pct);
      send_item(make_item(REQ_UNUSED_FIRST,        8'hFF, 9'd256), idle_pct);
      send_item(make_item(REQ_UNUSED_FIRST + 3'd1, 8'h5A, 9'd1),   idle_pct);
      send_item(make_item(REQ_UNUSED_LAST,         8'hFF, 9'd256), idle_pct);
      send_item(make_item(REQ_PUSH, 8'h00, 9'd256), idle_pct);
      send_item(make_item(REQ_PUSH, 8'hFF, 9'd0),   idle_pct);
      send_item(make_item(REQ_PUSH, 8'hA5, 9'd1),   idle_pct);
      send_item(make_item(REQ_PUSH, 8'h5A, 9'd255), idle_pct);
      send_item(make_item(REQ_PEEK,   8'h00, 9'd256), idle_pct);
      send_item(make_item(REQ_PEEK,   8'h00, 9'd2),   idle_pct);
      send_item(make_item(REQ_POP,    8'h00, 9'd1),   idle_pct);
      send_item(make_item(REQ_LINEAR, 8'h00, 9'd256), idle_pct);
      send_item(make_item(REQ_LINEAR, 8'h00, 9'd1),   idle_pct);
      send_item(make_item(REQ_SKIP,   8'h00, 9'd1),   idle_pct);
      send_item(make_item(REQ_POP,    8'h00, 9'd0),   idle_pct);
      send_item(make_item(REQ_POP,    8'h00, 9'd256), idle_pct);
      send_item(make_item(REQ_SKIP,   8'h00, 9'd256), idle_pct);
   endtask

   task automatic run_phase(int n_items, int idle_pct);
      int sent;
      int k;
      sent = 0;
      while (sent < n_items) begin
         if ($urandom_range(99) < 6) begin
            // fill run, then one burst read with a mostly uncapped count
            k = fifo_state.min_of($urandom_range(1, 72), n_items - sent - 1);
            repeat (k)
               send_item(make_item(REQ_PUSH, 8'($urandom), rand_count()), idle_pct);
            send_item(make_item($urandom_range(1) ? REQ_POP : REQ_PEEK, 8'($urandom),
                                $urandom_range(1) ? CNT_BITS'(DEPTH) : rand_count()),
                      idle_pct);
            sent += k + 1;
         end else begin
            send_item(make_item(rand_op(), 8'($urandom), rand_count()), idle_pct);
            sent++;
         end
      end
   endtask

   initial begin
      int idle_pct;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      run_directed(19);
      for (int p = 0; p < 8; p++) begin
         idle_pct = (p < 3) ? 19 : (p < 6) ? 48 : 0;
         settle();
         write_capacity(cap_plan[p]);
         run_phase(44, idle_pct);
      end
      settle();
      if (fifo_state.errors == 0 && fifo_state.pending() == 0) begin
         $display("testbench passed");
      end else begin
         $display("testbench failed");
      end
      $finish;
   end

   initial begin
      #(6_000_000);
      $display("testbench failed");
      $finish;
   end

endmodule
